FILE: rtl/multi_source_hid_key_merger_macros.svh
// assertion macros used by the checker file
`ifndef MULTI_SOURCE_HID_KEY_MERGER_MACROS_SVH
`define MULTI_SOURCE_HID_KEY_MERGER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HKM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define HKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/hkm_pkg.sv
// shared types, codes and helper functions of the key merger
package hkm_pkg;

    localparam logic [2:0] OP_PRESS   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_WEAK    = 3'd3;
    localparam logic [2:0] OP_LOAD    = 3'd4;
    localparam logic [2:0] OP_RESEND  = 3'd5;
    localparam logic [2:0] OP_COMPOSE = 3'd6;
    localparam logic [2:0] OP_READ    = 3'd7;

    localparam int          ROWS      = 4;
    localparam int          ROW_W     = 64;
    localparam int          SLOTS     = 6;
    localparam logic [7:0]  ROLLOVER  = 8'h01;
    localparam logic [7:0]  RESEND_FILL = 8'hFF;

    // memory port request between controller and bitmap store
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [1:0] addr;
    } mem_req_t;

    // usages 0x04..0xDF that take part in the scan, per row of 64
    function automatic logic [ROW_W-1:0] scan_mask(input logic [1:0] row);
        logic [ROW_W-1:0] m;
        begin
            m = '1;
            if (row == 2'd0)
            begin
                m[3:0] = 4'b0000;
            end
            if (row == 2'd3)
            begin
                m[63:32] = '0;
            end
            return m;
        end
    endfunction

    // position of the lowest set bit
    function automatic logic [5:0] lowest_bit(input logic [ROW_W-1:0] v);
        logic [5:0] idx;
        begin
            idx = '0;
            for (int i = ROW_W - 1; i >= 0; i--)
            begin
                if (v[i])
                begin
                    idx = 6'(i);
                end
            end
            return idx;
        end
    endfunction

endpackage

FILE: rtl/hkm_bitmap_mem.sv
// held-key bitmap store: one row per 64 usages, all sources side by side
module hkm_bitmap_mem #(
    parameter int W = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hkm_pkg::mem_req_t req,
    input  logic [W-1:0]     wdata,
    output logic [W-1:0]     rdata
);
    import hkm_pkg::*;

    logic [W-1:0]      mem [ROWS];
    logic [W-1:0]      rd_reg;
    logic [ROWS-1:0]   valid_reg;
    logic              rd_valid_reg;

    // array write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= wdata;
        end
        if (req.rd_en)
        begin
            rd_reg <= mem[req.addr];
        end
    end

    // row valid bits stand in for the reset clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

FILE: rtl/multi_source_hid_key_merger.sv
// top level: event controller, modifier registers and report composer
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid/in_ready, op + payload  | request in
//  out     | out_valid/out_ready, report etc. | request out
//
// register-only events go straight to the result; press/release read and write back one row
// clear and load read and write back each of the 4 rows, then give the result
// compose reads the rows in turn and picks their held keys; a seventh key ends it with rollover
// row valid bits clear the bitmap at reset, no clearing pass is needed
// a stalled result holds in the output register; the next request waits for it
module multi_source_hid_key_merger #(
    parameter int SOURCES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic [1:0] source,
    input  logic [7:0] usage,
    input  logic [7:0] mod_byte,
    input  logic [7:0] key_a,
    input  logic [7:0] key_b,
    input  logic [7:0] key_c,
    input  logic [7:0] key_d,
    input  logic [7:0] key_e,
    input  logic [7:0] key_f,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       report_changed,
    output logic [7:0] report_mods,
    output logic [7:0] slot_a,
    output logic [7:0] slot_b,
    output logic [7:0] slot_c,
    output logic [7:0] slot_d,
    output logic [7:0] slot_e,
    output logic [7:0] slot_f,
    output logic [7:0] source_mods,
    output logic       pending
);
    import hkm_pkg::*;

    localparam int W = SOURCES * ROW_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WB   = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg;
    logic [1:0]  src_reg;
    logic [7:0]  usage_reg;
    logic [7:0]  mb_reg;
    logic [7:0]  keys_reg [SLOTS];
    logic [1:0]  row_reg;
    logic [ROW_W-1:0] scan_reg;
    logic [2:0]  n_reg;
    logic        over_reg;
    logic [7:0]  slots_reg [SLOTS];
    logic [7:0]  real_reg [SOURCES];
    logic [7:0]  weak_reg [SOURCES];
    logic [63:0] last_reg;
    logic        dirty_reg;
    logic        res_changed_reg;
    logic [7:0]  res_mods_reg;
    logic [7:0]  res_slots_reg [SLOTS];
    logic [7:0]  res_src_reg;
    logic        out_valid_reg;
    logic [7:0]  o_slots_reg [SLOTS];
    logic        o_changed_reg;
    logic [7:0]  o_mods_reg;
    logic [7:0]  o_src_reg;
    logic        o_pending_reg;

    mem_req_t    req;
    logic [W-1:0] wdata;
    logic [W-1:0] rdata;
    logic        accept;
    logic        emit;
    logic [ROW_W-1:0] new_slice;
    logic [ROW_W-1:0] load_mask;
    logic [ROW_W-1:0] union_row;
    logic [7:0]  all_mods;
    logic [63:0] rep;
    logic [7:0]  rep_slots [SLOTS];

    hkm_bitmap_mem #(.W(W)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign accept = in_valid && in_ready;
    assign emit   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);

    // memory request: one read then, except for compose, one write back per row, never overlapping
    always_comb
    begin
        req.rd_en = (state_reg == S_RD);
        req.wr_en = (state_reg == S_WB) && (op_reg != OP_COMPOSE);
        req.addr  = row_reg;
    end

    // six-key load mask for the current row
    always_comb
    begin
        load_mask = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (keys_reg[j] > 8'd1 && keys_reg[j][7:6] == row_reg)
            begin
                load_mask[keys_reg[j][5:0]] = 1'b1;
            end
        end
    end

    // modified slice of the event's source
    always_comb
    begin
        new_slice = rdata[32'(src_reg) * ROW_W +: ROW_W];
        if (op_reg == OP_PRESS || op_reg == OP_RELEASE)
        begin
            new_slice[usage_reg[5:0]] = (op_reg == OP_PRESS);
        end
        else
        begin
            new_slice = (op_reg == OP_LOAD) ? load_mask : '0;
        end
        wdata = rdata;
        wdata[32'(src_reg) * ROW_W +: ROW_W] = new_slice;
    end

    // union across sources and all modifiers
    always_comb
    begin
        union_row = '0;
        all_mods  = '0;
        for (int i = 0; i < SOURCES; i++)
        begin
            union_row = union_row | rdata[i * ROW_W +: ROW_W];
            all_mods  = all_mods | real_reg[i] | weak_reg[i];
        end
        union_row = union_row & scan_mask(row_reg);
    end

    // assembled report: modifiers, reserved zero, six slots
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            rep_slots[j] = over_reg ? ROLLOVER : slots_reg[j];
        end
        rep = {rep_slots[5], rep_slots[4], rep_slots[3], rep_slots[2],
               rep_slots[1], rep_slots[0], 8'h00, all_mods};
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_COMPOSE)
                    begin
                        state_next = S_RD;
                    end
                    else if ((operation == OP_PRESS || operation == OP_RELEASE)
                             && {30'd0, source} < SOURCES && usage != 8'd0)
                    begin
                        state_next = S_RD;
                    end
                    else if ((operation == OP_CLEAR || operation == OP_LOAD)
                             && {30'd0, source} < SOURCES)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (op_reg == OP_COMPOSE)
                begin
                    state_next = S_PICK;
                end
                else if (op_reg == OP_PRESS || op_reg == OP_RELEASE || row_reg == 2'd3)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_PICK:
            begin
                if (scan_reg == '0)
                begin
                    state_next = (row_reg == 2'd3) ? S_FIN : S_RD;
                end
                else if (n_reg == 3'(SLOTS))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dirty_reg     <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SOURCES; i++)
            begin
                real_reg[i] <= '0;
                weak_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // register-only events
            if (accept)
            begin
                if (operation == OP_WEAK && {30'd0, source} < SOURCES
                    && weak_reg[source] != mod_byte)
                begin
                    weak_reg[source] <= mod_byte;
                    dirty_reg        <= 1'b1;
                end
                if (operation == OP_RESEND)
                begin
                    last_reg  <= {8{RESEND_FILL}};
                    dirty_reg <= 1'b1;
                end
            end
            // bitmap write back
            if (state_reg == S_WB && op_reg != OP_COMPOSE)
            begin
                dirty_reg <= 1'b1;
                if (op_reg == OP_PRESS || op_reg == OP_RELEASE)
                begin
                    if (usage_reg[7:3] == 5'b11100)
                    begin
                        real_reg[src_reg] <= new_slice[32 +: 8];
                    end
                end
                else
                begin
                    real_reg[src_reg] <= (op_reg == OP_LOAD) ? mb_reg : 8'h00;
                    weak_reg[src_reg] <= '0;
                end
            end
            // compose result
            if (state_reg == S_FIN)
            begin
                dirty_reg <= 1'b0;
                if (rep != last_reg)
                begin
                    last_reg <= rep;
                end
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= operation;
            src_reg     <= source;
            usage_reg   <= usage;
            mb_reg      <= mod_byte;
            keys_reg[0] <= key_a;
            keys_reg[1] <= key_b;
            keys_reg[2] <= key_c;
            keys_reg[3] <= key_d;
            keys_reg[4] <= key_e;
            keys_reg[5] <= key_f;
            row_reg     <= (operation == OP_PRESS || operation == OP_RELEASE)
                           ? usage[7:6] : 2'd0;
            n_reg       <= '0;
            over_reg    <= 1'b0;
            res_changed_reg <= 1'b0;
            res_mods_reg    <= '0;
            res_src_reg     <= (operation == OP_READ && {30'd0, source} < SOURCES)
                               ? (real_reg[source] | weak_reg[source]) : 8'h00;
            for (int j = 0; j < SLOTS; j++)
            begin
                slots_reg[j]     <= '0;
                res_slots_reg[j] <= '0;
            end
        end
        if (state_reg == S_WB)
        begin
            if (op_reg == OP_COMPOSE)
            begin
                scan_reg <= union_row;
            end
            else if (op_reg == OP_CLEAR || op_reg == OP_LOAD)
            begin
                row_reg <= row_reg + 2'd1;
            end
        end
        // one held key per cycle in the pick state, lowest usage first
        if (state_reg == S_PICK)
        begin
            if (scan_reg == '0)
            begin
                row_reg <= row_reg + 2'd1;
            end
            else if (n_reg == 3'(SLOTS))
            begin
                over_reg <= 1'b1;
            end
            else
            begin
                slots_reg[n_reg] <= {row_reg, lowest_bit(scan_reg)};
                n_reg            <= n_reg + 3'd1;
                scan_reg[lowest_bit(scan_reg)] <= 1'b0;
            end
        end
        if (state_reg == S_FIN && rep != last_reg)
        begin
            res_changed_reg <= 1'b1;
            res_mods_reg    <= all_mods;
            for (int j = 0; j < SLOTS; j++)
            begin
                res_slots_reg[j] <= rep_slots[j];
            end
        end
        // output register
        if (emit)
        begin
            o_changed_reg <= res_changed_reg;
            o_mods_reg    <= res_mods_reg;
            o_src_reg     <= res_src_reg;
            o_pending_reg <= dirty_reg;
            for (int j = 0; j < SLOTS; j++)
            begin
                o_slots_reg[j] <= res_slots_reg[j];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign report_changed = o_changed_reg;
    assign report_mods    = o_mods_reg;
    assign slot_a         = o_slots_reg[0];
    assign slot_b         = o_slots_reg[1];
    assign slot_c         = o_slots_reg[2];
    assign slot_d         = o_slots_reg[3];
    assign slot_e         = o_slots_reg[4];
    assign slot_f         = o_slots_reg[5];
    assign source_mods    = o_src_reg;
    assign pending        = o_pending_reg;

endmodule

FILE: rtl/hkm_checker.sv
// port-level checker of the key merger and its bind
`include "multi_source_hid_key_merger_macros.svh"

module hkm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       report_changed,
    input logic [7:0] report_mods,
    input logic [7:0] slot_a,
    input logic [7:0] source_mods,
    input logic       pending
);

    // a waiting result stays
    `HKM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // one request at a time
    `HKM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // report fields are zero unless a new report goes out
    `HKM_ASSERT_NOW(a_quiet_report, clk, rst_n, out_valid && !report_changed,
        report_mods == 8'h00 && slot_a == 8'h00)
    // a new report comes from compose, which clears the dirty flag
    `HKM_ASSERT_NOW(a_compose_clean, clk, rst_n, out_valid && report_changed,
        !pending && source_mods == 8'h00)

endmodule

bind multi_source_hid_key_merger hkm_checker u_hkm_checker (.*);
